[src/bdown_pkg.sv]
// shared types, constants and arithmetic helpers of the blur/downsample block
`timescale 1ns / 1ps
package bdown_pkg;

   // frame limits and field widths
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 12;
   localparam int PIX_W      = 8;
   localparam int HSUM_W     = 12;
   localparam int ACC_W      = 16;
   localparam int OUT_IDX_W  = 10;
   localparam int CSR_IDX_W  = 2;

   // job queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;

   typedef logic [HSUM_W-1:0] hsum_type;
   // horizontal sums of one column, entry d holds source row y-d
   typedef hsum_type [4:0] column_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } dims_type;

   // one queued item: its position, the rows and columns it releases and the sums
   typedef struct packed {
      logic [COL_W-1:0] x;
      logic [ROW_W-1:0] y;
      logic [2:0]       ymin;
      logic [1:0]       r_dr0;
      logic             r_two;
      logic [1:0]       c_dc0;
      logic             c_two;
      column_type       col0;
      column_type       col1;
   } job_type;

   // binomial tap weights
   function automatic logic [2:0] tap5(input int i);
      logic [2:0] t;
      case (i)
         1, 3:    t = 3'd4;
         2:       t = 3'd6;
         default: t = 3'd1;
      endcase
      return t;
   endfunction

   // distance offset (two's complement, -8..7) clamped to 0..lim
   function automatic logic [2:0] clamp_d(input logic [3:0] v, input logic [2:0] lim);
      logic [2:0] d;
      if (v[3]) d = 3'd0;
      else if (v[2:0] > lim) d = lim;
      else d = v[2:0];
      return d;
   endfunction

   // horizontal sum of column x-dc, px[d] is the pixel at column x-d
   function automatic hsum_type hsum5(input logic [4:0][PIX_W-1:0] px,
                                      input logic [1:0] dc, input logic [2:0] lim);
      hsum_type   s;
      logic [2:0] d;
      s = '0;
      for (int i = 0; i < 5; i++) begin
         d = clamp_d(4'(dc) + 4'd2 - 4'(i), lim);
         s = s + HSUM_W'(px[d]) * HSUM_W'(tap5(i));
      end
      return s;
   endfunction

   // vertical sum over one column record for output row y-dr
   function automatic logic [ACC_W-1:0] vsum5(input column_type col,
                                              input logic [1:0] dr, input logic [2:0] lim);
      logic [ACC_W-1:0] s;
      logic [2:0]       d;
      s = '0;
      for (int i = 0; i < 5; i++) begin
         d = clamp_d(4'(dr) + 4'd2 - 4'(i), lim);
         s = s + ACC_W'(col[d]) * ACC_W'(tap5(i));
      end
      return s;
   endfunction

   // saturate a size register into 1..mx
   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] mx);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > mx) r = mx;
      else r = v;
      return r;
   endfunction

endpackage

[src/bdown_front.sv]
// front end: position counters, horizontal pass, line stores and job building
`timescale 1ns / 1ps
module bdown_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [bdown_pkg::PIX_W-1:0]       req_pixel,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bdown_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bdown_pkg::DIM_W-1:0]       csr_data,
   input  logic [bdown_pkg::Q_LVL_W-1:0]     q_level,
   output logic                              q_push,
   output bdown_pkg::job_type                q_job,
   output bdown_pkg::dims_type               dims
);
   import bdown_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [COL_W-1:0] x_ff, x_in;
   logic [ROW_W-1:0] y_ff, y_in;
   logic [PIX_W-1:0] win_ff [4];
   hsum_type         edge_ff [4][2];
   hsum_type         rd_ff [4];

   logic             accept, cfg_hit, last_col, last_row;
   logic [DIM_W-1:0] wsat, hsat;
   logic [2:0]       xmin, ymin;
   logic [4:0][PIX_W-1:0] px;
   hsum_type         h0, h1, h2;
   logic             has_r, r_two, has_c, c_two;
   logic [1:0]       r_dr0, c_dc0;
   logic [COL_W-1:0] mem_addr;
   logic             mem_we;
   column_type       ce0, ce1;

   // stage between accept and queue
   logic             b_valid_ff;
   job_type          b_job_ff;
   hsum_type         b_h2_ff;
   column_type       b_ce0_ff;

   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;
   assign cfg_hit   = csr_valid && (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT);
   assign req_full  = ({1'b0, q_level} + (Q_LVL_W + 1)'(b_valid_ff))
                      >= (Q_LVL_W + 1)'(Q_DEPTH);

   assign wsat = sat_dim(width_ff, DIM_W'(MAX_WIDTH));
   assign hsat = sat_dim(height_ff, DIM_W'(MAX_HEIGHT));
   assign dims = '{width: wsat, height: hsat};

   assign last_col = ({{(DIM_W-COL_W){1'b0}}, x_ff} == wsat - DIM_W'(1));
   assign last_row = ({{(DIM_W-ROW_W){1'b0}}, y_ff} == hsat - DIM_W'(1));
   assign xmin = (x_ff >= COL_W'(4)) ? 3'd4 : x_ff[2:0];
   assign ymin = (y_ff >= ROW_W'(4)) ? 3'd4 : y_ff[2:0];

   // horizontal sums for columns x, x-1 and x-2
   always_comb begin
      px[0] = req_pixel;
      for (int i = 0; i < 4; i++) px[i+1] = win_ff[i];
   end
   assign h0 = hsum5(px, 2'd0, xmin);
   assign h1 = hsum5(px, 2'd1, xmin);
   assign h2 = hsum5(px, 2'd2, xmin);

   // which output rows and columns this pixel releases
   always_comb begin
      if (last_row) begin
         has_r = 1'b1;
         if (!y_ff[0]) begin
            r_two = (y_ff >= ROW_W'(2));
            r_dr0 = r_two ? 2'd2 : 2'd0;
         end else begin
            r_two = 1'b0;
            r_dr0 = 2'd1;
         end
      end else begin
         has_r = (y_ff >= ROW_W'(2)) && !y_ff[0];
         r_two = 1'b0;
         r_dr0 = 2'd2;
      end
      if (last_col) begin
         has_c = 1'b1;
         if (!x_ff[0]) begin
            c_two = (x_ff >= COL_W'(2));
            c_dc0 = c_two ? 2'd2 : 2'd0;
         end else begin
            c_two = 1'b0;
            c_dc0 = 2'd1;
         end
      end else begin
         has_c = (x_ff >= COL_W'(2)) && !x_ff[0];
         c_two = 1'b0;
         c_dc0 = 2'd2;
      end
   end

   // records of the two rightmost columns, older rows from the edge shift line
   always_comb begin
      ce0[0] = h1;
      ce1[0] = h0;
      for (int d = 1; d < 5; d++) begin
         ce0[d] = edge_ff[d-1][0];
         ce1[d] = edge_ff[d-1][1];
      end
   end

   // config registers and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(640);
         height_ff <= DIM_W'(480);
         x_ff      <= '0;
         y_ff      <= '0;
      end else begin
         if (csr_valid && csr_index == CSR_WIDTH)  width_ff  <= csr_data;
         if (csr_valid && csr_index == CSR_HEIGHT) height_ff <= csr_data;
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (cfg_hit) begin
         x_in = '0;
         y_in = '0;
      end else if (accept) begin
         if (last_col) begin
            x_in = '0;
            y_in = last_row ? '0 : y_ff + ROW_W'(1);
         end else begin
            x_in = x_ff + COL_W'(1);
         end
      end
   end

   // pixel window and edge column shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) win_ff[i] <= '0;
      end else if (accept) begin
         win_ff[0] <= req_pixel;
         for (int i = 1; i < 4; i++) win_ff[i] <= win_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last_col) begin
         edge_ff[0][0] <= h1;
         edge_ff[0][1] <= h0;
         for (int i = 1; i < 4; i++) edge_ff[i] <= edge_ff[i-1];
      end
   end

   // line stores, one per row slot, read before write
   assign mem_addr = x_ff - COL_W'(2);
   assign mem_we   = accept && (x_ff >= COL_W'(2));

   for (genvar s = 0; s < 4; s++) begin : g_line
      hsum_type mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (mem_we && y_ff[1:0] == 2'(s)) mem[mem_addr] <= h2;
         if (accept) rd_ff[s] <= mem[mem_addr];
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else       b_valid_ff <= accept && has_r && has_c;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_job_ff.x     <= x_ff;
         b_job_ff.y     <= y_ff;
         b_job_ff.ymin  <= ymin;
         b_job_ff.r_dr0 <= r_dr0;
         b_job_ff.r_two <= r_two;
         b_job_ff.c_dc0 <= c_dc0;
         b_job_ff.c_two <= c_two;
         b_job_ff.col0  <= '0;
         b_job_ff.col1  <= ce1;
         b_h2_ff        <= h2;
         b_ce0_ff       <= ce0;
      end
   end

   // finish the first column record: from the line store data for column x-2, else from the edge records
   always_comb begin
      q_job = b_job_ff;
      unique case (b_job_ff.c_dc0)
         2'd2: begin
            q_job.col0[0] = b_h2_ff;
            for (int d = 1; d < 5; d++)
               q_job.col0[d] = rd_ff[b_job_ff.y[1:0] - 2'(d)];
         end
         2'd1:    q_job.col0 = b_ce0_ff;
         default: q_job.col0 = b_job_ff.col1;
      endcase
   end

   assign q_push = b_valid_ff;

endmodule

[src/bdown_queue.sv]
// short job queue between front and back
`timescale 1ns / 1ps
module bdown_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  bdown_pkg::job_type            push_job,
   input  logic                          pop,
   output logic                          head_valid,
   output bdown_pkg::job_type            head_job,
   output logic [bdown_pkg::Q_LVL_W-1:0] level
);
   import bdown_pkg::*;

   job_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ff, rd_ff;
   logic [Q_LVL_W-1:0]   level_ff, level_in;
   logic                 do_pop;

   assign do_pop     = pop && head_valid;
   assign head_valid = (level_ff != '0);
   assign head_job   = slot_ff[rd_ff];
   assign level      = level_ff;

   // level follows pushes and pops
   always_comb begin
      level_in = level_ff;
      if (push && !do_pop) level_in = level_ff + Q_LVL_W'(1);
      else if (!push && do_pop) level_in = level_ff - Q_LVL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         if (push)   wr_ff <= wr_ff + Q_PTR_W'(1);
         if (do_pop) rd_ff <= rd_ff + Q_PTR_W'(1);
         level_ff <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

`ifndef SYNTH
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= Q_LVL_W'(Q_DEPTH))
      else $error("queue level above depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !do_pop) |-> (level_ff < Q_LVL_W'(Q_DEPTH)))
      else $error("push into full queue");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (level_ff != '0 && level_ff != Q_LVL_W'(Q_DEPTH)) |-> (wr_ff != rd_ff))
      else $error("pointers disagree with level");
`endif

endmodule

[src/bdown_back.sv]
// back end: vertical pass, rounding and result register, one result a cycle while the receiver pops
`timescale 1ns / 1ps
module bdown_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  bdown_pkg::job_type                  head_job,
   output logic                                q_pop,
   input  bdown_pkg::dims_type                 dims,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [bdown_pkg::PIX_W-1:0]         rsp_out_pixel,
   output logic [bdown_pkg::OUT_IDX_W-1:0]     rsp_out_col,
   output logic [bdown_pkg::OUT_IDX_W-1:0]     rsp_out_row,
   output logic                                rsp_row_end,
   output logic                                rsp_frame_end,
   output logic                                rsp_last
);
   import bdown_pkg::*;

   logic             ri_ff, ci_ff, ri_in, ci_in;
   logic             o_valid_ff;
   logic             step, done;
   logic [1:0]       dr, dc;
   column_type       colv;
   logic [ACC_W-1:0] acc, acc_rnd;
   logic [COL_W-1:0] c;
   logic [ROW_W-1:0] r;
   logic [DIM_W-1:0] ow_last, oh_last;

   assign step  = head_valid && (!o_valid_ff || rsp_pop);
   assign done  = !(!ci_ff && head_job.c_two) && !(!ri_ff && head_job.r_two);
   assign q_pop = step && done;

   // current output of this item, rows outer and columns inner
   assign dr      = ri_ff ? 2'd0 : head_job.r_dr0;
   assign dc      = ci_ff ? 2'd0 : head_job.c_dc0;
   assign colv    = ci_ff ? head_job.col1 : head_job.col0;
   assign acc     = vsum5(colv, dr, head_job.ymin);
   assign acc_rnd = acc + ACC_W'(128);
   assign c       = head_job.x - COL_W'(dc);
   assign r       = head_job.y - ROW_W'(dr);
   assign ow_last = (dims.width - DIM_W'(1)) >> 1;
   assign oh_last = (dims.height - DIM_W'(1)) >> 1;

   // walk through the outputs of the head item
   always_comb begin
      ri_in = ri_ff;
      ci_in = ci_ff;
      if (step) begin
         if (!ci_ff && head_job.c_two) begin
            ci_in = 1'b1;
         end else if (!ri_ff && head_job.r_two) begin
            ri_in = 1'b1;
            ci_in = 1'b0;
         end else begin
            ri_in = 1'b0;
            ci_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ri_ff      <= 1'b0;
         ci_ff      <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         ri_ff <= ri_in;
         ci_ff <= ci_in;
         if (step)         o_valid_ff <= 1'b1;
         else if (rsp_pop) o_valid_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_out_pixel <= acc_rnd[ACC_W-1:ACC_W-PIX_W];
         rsp_out_col   <= c[OUT_IDX_W:1];
         rsp_out_row   <= r[OUT_IDX_W:1];
         rsp_row_end   <= (DIM_W'(c >> 1) == ow_last);
         rsp_frame_end <= (DIM_W'(c >> 1) == ow_last) && (DIM_W'(r >> 1) == oh_last);
         rsp_last      <= done;
      end
   end

   assign rsp_empty = !o_valid_ff;

`ifndef SYNTH
   a_row_walk: assert property (@(posedge clock) disable iff (reset)
      (ri_ff && head_valid) |-> head_job.r_two)
      else $error("second row walked without a second row");
   a_col_walk: assert property (@(posedge clock) disable iff (reset)
      (ci_ff && head_valid) |-> head_job.c_two)
      else $error("second column walked without a second column");
   a_idle_walk: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (!ri_ff && !ci_ff))
      else $error("walk state left over without a queued item");
`endif

endmodule

[src/binomial5x5_blur_downsample2x.sv]
// top level of the 5x5 binomial blur with 2x downsampling
`timescale 1ns / 1ps
// Grey pixels enter in raster order, one word per cycle, and leave as a
// blurred half-size image with their output column, row and end flags. The
// front takes one pixel every clock: the horizontal pass and the four line
// stores (one read and one write port each) work at that rate. A pixel that
// releases outputs adds one item to a four-entry queue, and the back drains
// one result per clock while the receiver pops, so a pixel releasing n
// results (up to four at the right and bottom edges) holds the back until
// all are out; pixel input stalls only once the queue fills. Writing either
// size register restarts the frame at row 0, column 0; the line stores need
// no clearing after reset.
module binomial5x5_blur_downsample2x (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [bdown_pkg::PIX_W-1:0]         req_pixel,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [bdown_pkg::PIX_W-1:0]         rsp_out_pixel,
   output logic [bdown_pkg::OUT_IDX_W-1:0]     rsp_out_col,
   output logic [bdown_pkg::OUT_IDX_W-1:0]     rsp_out_row,
   output logic                                rsp_row_end,
   output logic                                rsp_frame_end,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdown_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bdown_pkg::DIM_W-1:0]         csr_data
);
   import bdown_pkg::*;

   logic               q_push, q_pop, head_valid;
   job_type            q_job, head_job;
   logic [Q_LVL_W-1:0] q_level;
   dims_type           dims;

   // pixel intake and horizontal pass
   bdown_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_pixel (req_pixel),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_level   (q_level),
      .q_push    (q_push),
      .q_job     (q_job),
      .dims      (dims)
   );

   // decoupling queue
   bdown_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .level      (q_level)
   );

   // vertical pass and results
   bdown_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .q_pop         (q_pop),
      .dims          (dims),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .rsp_last      (rsp_last)
   );

endmodule

[verif/tb_binomial5x5_blur_downsample2x.sv]
// self-checking testbench for the 5x5 binomial blur with 2x downsampling
`timescale 1ns / 1ps
module tb_binomial5x5_blur_downsample2x;
   import bdown_pkg::*;

   // one expected output word
   typedef struct {
      logic [PIX_W-1:0]     pix;
      logic [OUT_IDX_W-1:0] col;
      logic [OUT_IDX_W-1:0] row;
      logic                 row_end;
      logic                 frame_end;
      logic                 last;
   } blur_word_type;

   // one row of the directed table: a register write or a pixel
   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [DIM_W-1:0]     data;
      logic [PIX_W-1:0]     pix;
      bit                   typed;
      logic [PIX_W-1:0]     typed_pix;
   } dir_row_type;

   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;

   // register indexes that select no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE0 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE1 = 2'd3;

   logic                 clock, reset;
   logic                 req_push, req_full;
   logic [PIX_W-1:0]     req_pixel;
   logic                 rsp_empty, rsp_pop;
   logic [PIX_W-1:0]     rsp_out_pixel;
   logic [OUT_IDX_W-1:0] rsp_out_col, rsp_out_row;
   logic                 rsp_row_end, rsp_frame_end, rsp_last;
   logic                 csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_data;

   binomial5x5_blur_downsample2x dut (.*);

   // shadow of the block's state
   logic [DIM_W-1:0]  shadow_w, shadow_h;
   int                pos_col, pos_row;
   logic [PIX_W-1:0]  prev_px [4];
   logic [HSUM_W-1:0] line_sums [4][MAX_WIDTH];

   blur_word_type blur_q[$];
   dir_row_type   dir_tab[$];
   int            errors = 0;
   int            words_seen = 0;
   int            pixels_sent, csr_writes;
   int            hold_left;
   bit            hold_used;
   bit            calm, hold, hold_go;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // deadline for the whole run
   initial begin
      #400000;
      $display("timeout waiting for output words");
      $display("DONE: errors detected");
      $finish;
   end

   // receiver hold-off, counted in cycles once the stimulus asks for it
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_go && !hold_used) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   assign hold = (hold_left != 0);

   function automatic bit take_break();
      return !calm && ($urandom_range(0, 99) < 8);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, words_seen);
      errors++;
   endtask

   function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int mx);
      if (v == 0) return 1;
      if (v > mx) return mx;
      return v;
   endfunction

   // pixel j of the current row, x is the current column
   function automatic int row_px(input int j, input int x, input logic [PIX_W-1:0] cur);
      int d;
      if (j < 0) j = 0;
      if (j > x) j = x;
      d = x - j;
      if (d == 0) return cur;
      return prev_px[(d - 1) & 3];
   endfunction

   function automatic int hsum_at(input int c, input int x, input logic [PIX_W-1:0] cur);
      return row_px(c - 2, x, cur) + 4 * row_px(c - 1, x, cur) + 6 * row_px(c, x, cur)
           + 4 * row_px(c + 1, x, cur) + row_px(c + 2, x, cur);
   endfunction

   // advance the shadow by one pixel and queue the words it releases
   task automatic predict_blur(input logic [PIX_W-1:0] cur, input bit typed,
                               input logic [PIX_W-1:0] typed_pix);
      int w, h, x, y, c_lo, c_hi, r_lo, r_hi, sr, v, out_w, out_h;
      int tap [5];
      int hs [3];
      int acc;
      blur_word_type words[$];
      blur_word_type bw;
      tap = '{1, 4, 6, 4, 1};
      w = clamp_dim(shadow_w, MAX_WIDTH);
      h = clamp_dim(shadow_h, MAX_HEIGHT);
      out_w = (w + 1) / 2;
      out_h = (h + 1) / 2;
      if (pos_col >= w || pos_row >= h) begin
         pos_col = 0;
         pos_row = 0;
      end
      x = pos_col;
      y = pos_row;
      c_lo = (x - 2 < 0) ? 0 : x - 2;
      c_hi = (x == w - 1) ? x : x - 2;
      for (int c = c_lo; c <= c_hi; c++) hs[(c - x + 2) % 3] = hsum_at(c, x, cur);
      r_lo = (y - 2 < 0) ? 0 : y - 2;
      r_hi = (y == h - 1) ? y : y - 2;
      for (int r = r_lo; r <= r_hi; r++) begin
         if (r & 1) continue;
         for (int c = c_lo; c <= c_hi; c++) begin
            if (c & 1) continue;
            acc = 0;
            for (int k = 0; k < 5; k++) begin
               sr = r + k - 2;
               if (sr < 0) sr = 0;
               if (sr > h - 1) sr = h - 1;
               if (sr > y) sr = y;
               v = (sr == y) ? hs[(c - x + 2) % 3] : line_sums[sr & 3][c];
               acc += tap[k] * v;
            end
            bw.pix = PIX_W'((acc + 128) >> 8);
            bw.col = OUT_IDX_W'(c / 2);
            bw.row = OUT_IDX_W'(r / 2);
            bw.row_end = (c / 2 == out_w - 1);
            bw.frame_end = (c / 2 == out_w - 1) && (r / 2 == out_h - 1);
            bw.last = 1'b0;
            words.push_back(bw);
         end
      end
      if (words.size() > 0) words[words.size() - 1].last = 1'b1;
      // typed rows are only used on the single-pixel frame
      if (typed) begin
         bw = '{typed_pix, '0, '0, 1'b1, 1'b1, 1'b1};
         words = '{bw};
      end
      foreach (words[i]) blur_q.push_back(words[i]);
      for (int c = c_lo; c <= c_hi; c++) line_sums[y & 3][c] = HSUM_W'(hs[(c - x + 2) % 3]);
      prev_px[3] = prev_px[2];
      prev_px[2] = prev_px[1];
      prev_px[1] = prev_px[0];
      prev_px[0] = cur;
      pos_col++;
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= h) pos_row = 0;
      end
   endtask

   // offer one pixel word, leaving push high afterwards
   task automatic push_pixel(input logic [PIX_W-1:0] p, input bit typed = 0,
                             input logic [PIX_W-1:0] typed_pix = '0);
      if (take_break()) begin
         req_push <= 1'b0;
         do @(posedge clock); while (take_break());
      end
      req_push  <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (req_full);
      predict_blur(p, typed, typed_pix);
      pixels_sent++;
   endtask

   // register write once the block has drained
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
      req_push <= 1'b0;
      @(posedge clock);
      while (blur_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      if (idx == CSR_WIDTH || idx == CSR_HEIGHT) begin
         if (idx == CSR_WIDTH) shadow_w = data;
         else shadow_h = data;
         pos_col = 0;
         pos_row = 0;
      end
   endtask

   // result side: compare each popped word, then pick the next pop
   always @(posedge clock) begin
      blur_word_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (blur_q.size() == 0) begin
            report_mismatch("word with nothing expected, out_col", rsp_out_col, -1);
         end else begin
            want = blur_q.pop_front();
            if (rsp_out_pixel !== want.pix) report_mismatch("out_pixel", rsp_out_pixel, want.pix);
            if (rsp_out_col !== want.col) report_mismatch("out_col", rsp_out_col, want.col);
            if (rsp_out_row !== want.row) report_mismatch("out_row", rsp_out_row, want.row);
            if (rsp_row_end !== want.row_end)
               report_mismatch("row_end", rsp_row_end, want.row_end);
            if (rsp_frame_end !== want.frame_end)
               report_mismatch("frame_end", rsp_frame_end, want.frame_end);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
         end
         words_seen++;
      end
      rsp_pop <= !reset && !hold && !take_break();
   end

   // stimulus
   initial begin
      int w, h, n, rand_items;
      req_push  <= 1'b0;
      req_pixel <= '0;
      rsp_pop   <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      reset     <= 1'b1;
      calm = 0;
      hold_go = 0;
      pixels_sent = 0;
      csr_writes = 0;
      shadow_w = 12'd640;
      shadow_h = 12'd480;
      pos_col = 0;
      pos_row = 0;
      foreach (prev_px[i]) prev_px[i] = '0;
      foreach (line_sums[i, j]) line_sums[i][j] = '0;

      // reset sizes, then a single-pixel frame that passes pixels through, then 4x4
      dir_tab.push_back('{0, '0, '0, 8'h00, 0, '0});
      dir_tab.push_back('{0, '0, '0, 8'hFF, 0, '0});
      dir_tab.push_back('{0, '0, '0, 8'hA5, 0, '0});
      dir_tab.push_back('{1, CSR_WIDTH, 12'd0, '0, 0, '0});
      dir_tab.push_back('{1, CSR_HEIGHT, 12'd0, '0, 0, '0});
      dir_tab.push_back('{0, '0, '0, 8'h00, 1, 8'h00});
      dir_tab.push_back('{0, '0, '0, 8'hFF, 1, 8'hFF});
      dir_tab.push_back('{0, '0, '0, 8'hAA, 1, 8'hAA});
      dir_tab.push_back('{0, '0, '0, 8'h55, 1, 8'h55});
      dir_tab.push_back('{1, CSR_SPARE0, 12'hFFF, '0, 0, '0});
      dir_tab.push_back('{1, CSR_SPARE1, 12'h000, '0, 0, '0});
      dir_tab.push_back('{0, '0, '0, 8'h80, 1, 8'h80});
      dir_tab.push_back('{1, CSR_WIDTH, 12'd4, '0, 0, '0});
      dir_tab.push_back('{1, CSR_HEIGHT, 12'd4, '0, 0, '0});
      for (int i = 0; i < 16; i++)
         dir_tab.push_back('{0, '0, '0, (i % 3 == 0) ? 8'hFF : 8'h00, 0, '0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_csr) write_csr(dir_tab[i].idx, dir_tab[i].data);
         else push_pixel(dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].typed_pix);
      end

      // widest frame as a single row, start of the row only, no idling from here
      calm = 1;
      write_csr(CSR_WIDTH, 12'hFFF);
      write_csr(CSR_HEIGHT, 12'd1);
      for (int i = 0; i < 40; i++) push_pixel($urandom_range(0, 255));

      // tallest frame, first rows only, receiver held off so the block fills
      write_csr(CSR_WIDTH, 12'd4);
      write_csr(CSR_HEIGHT, 12'hFFF);
      hold_go = 1;
      for (int i = 0; i < 48; i++) push_pixel($urandom_range(0, 255));

      // random small frames, whole frames with wrap and a partial tail
      rand_items = 0;
      while (rand_items < 250) begin
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 9);
         write_csr(CSR_WIDTH, DIM_W'(w));
         write_csr(CSR_HEIGHT, DIM_W'(h));
         if ($urandom_range(0, 3) == 0)
            write_csr(($urandom_range(0, 1) != 0) ? CSR_SPARE0 : CSR_SPARE1,
                      DIM_W'($urandom));
         n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
         for (int i = 0; i < n; i++) push_pixel($urandom_range(0, 255));
         rand_items += n;
         if (rand_items >= 100) calm = 0;
      end
      req_push <= 1'b0;

      while (blur_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d pixels, checked %0d output words, %0d register writes",
               pixels_sent, words_seen, csr_writes);
      $display("frames covered: 1x1, 4x4, widest row, tallest column, random small sizes");
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
